>>> rtl/lmas_pkg.sv
// Shared types, codes and pattern tables for the LED-matrix animation sequencer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package lmas_pkg;

    localparam int NumRows = 6;

    // Input request codes.
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ALL_ON = 3'd1;
    localparam logic [2:0] MODE_OFF    = 3'd2;
    localparam logic [2:0] MODE_BRIGHT = 3'd3;
    localparam logic [2:0] MODE_ANIM   = 3'd4;

    // Animation numbers.
    localparam logic [7:0] ANIM_NORMAL    = 8'd0;
    localparam logic [7:0] ANIM_MARCH     = 8'd1;
    localparam logic [7:0] ANIM_SPIN      = 8'd2;
    localparam logic [7:0] ANIM_RING      = 8'd3;
    localparam logic [7:0] ANIM_UPDOWN    = 8'd4;
    localparam logic [7:0] ANIM_LEFTRIGHT = 8'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FIRST_DELAY  = 2'd0;
    localparam logic [1:0] REG_SECOND_DELAY = 2'd1;
    localparam logic [1:0] REG_TRANSITION   = 2'd2;

    localparam logic [15:0] FIRST_DELAY_RESET  = 16'd1000;
    localparam logic [15:0] SECOND_DELAY_RESET = 16'd1000;
    localparam logic [15:0] TRANSITION_RESET   = 16'd300;
    localparam logic [15:0] THIRD_RESET        = 16'd100;

    // ceil(2^17 / 3): x * RECIP3 >> 17 equals x / 3 for every 16-bit x.
    localparam logic [32:0] RECIP3 = 33'd43691;

    localparam logic [15:0] SLOW_MS = 16'd250;
    localparam logic [15:0] SPIN_MS = 16'd50;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [3:0]  BRIGHT_RESET = 4'd15;

    localparam logic [3:0] NORMAL_LAST = 4'd8;
    localparam logic [3:0] NORMAL_MID  = 4'd4;
    localparam logic [3:0] SPIN_STEPS  = 4'd14;
    localparam logic [2:0] RING_TOP      = 3'd2;
    localparam logic [2:0] UPDOWN_TOP    = 3'd4;
    localparam logic [2:0] LEFTRIGHT_TOP = 3'd5;

    typedef logic [NumRows-1:0][7:0] frame_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic [15:0] first_delay;
        logic [15:0] second_delay;
        logic [15:0] third_transition;
    } cfg_t;

    typedef struct packed {
        logic [2:0] step;
        logic       down;
    } bounce_t;

    function automatic logic [7:0] stage_pat(input logic [3:0] s);
        logic [7:0] p;
        begin
            unique case (s)
                4'd0:    p = 8'h55;
                4'd1:    p = 8'hD5;
                4'd2:    p = 8'h95;
                4'd3:    p = 8'hB5;
                4'd4:    p = 8'hAA;
                4'd5:    p = 8'h2A;
                4'd6:    p = 8'h6A;
                default: p = 8'h55;
            endcase
            return p;
        end
    endfunction

    function automatic logic [2:0] spin_row(input logic [3:0] s);
        logic [2:0] r;
        begin
            unique case (s)
                4'd0, 4'd11, 4'd12, 4'd13: r = 3'd0;
                4'd1, 4'd10:               r = 3'd1;
                4'd2, 4'd9:                r = 3'd2;
                4'd3, 4'd8:                r = 3'd3;
                default:                   r = 3'd4;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] spin_bits(input logic [3:0] s);
        logic [7:0] b;
        begin
            unique case (s)
                4'd0, 4'd4:        b = 8'h40;
                4'd1, 4'd2, 4'd3:  b = 8'h80;
                4'd5, 4'd13:       b = 8'h20;
                4'd6, 4'd12:       b = 8'h10;
                4'd7, 4'd11:       b = 8'h08;
                default:           b = 8'h04;
            endcase
            return b;
        end
    endfunction

    function automatic logic [7:0] ring_img(input logic [1:0] s, input logic [2:0] r);
        logic [7:0] b;
        begin
            b = 8'h00;
            unique case (s)
                2'd0:    b = (r == 3'd0 || r == 3'd4) ? 8'h78 : 8'h84;
                2'd1:    b = (r == 3'd2) ? 8'h48 : ((r == 3'd1 || r == 3'd3) ? 8'h78 : 8'h00);
                2'd2:    b = (r == 3'd2) ? 8'h30 : 8'h00;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // Step a bouncing counter between 0 and top; out-of-range values restart it.
    function automatic bounce_t bounce(input logic [2:0] step, input logic down,
                                       input logic [2:0] top);
        bounce_t r;
        begin
            r.step = step;
            r.down = down;
            if (step > top)
            begin
                r.step = 3'd0;
                r.down = 1'b0;
            end
            else if (down)
            begin
                if (step == 3'd0)
                begin
                    r.step = 3'd1;
                    r.down = 1'b0;
                end
                else
                begin
                    r.step = step - 3'd1;
                end
            end
            else if (step == top)
            begin
                r.step = top - 3'd1;
                r.down = 1'b1;
            end
            else
            begin
                r.step = step + 3'd1;
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/lmas_cfg_regs.sv
// APB-style configuration registers: delay times and the derived transition hold.
// Depends on lmas_pkg.
module lmas_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lmas_pkg::cfg_t     cfg
);

    logic [15:0] first_reg;
    logic [15:0] second_reg;
    logic [15:0] transition_reg;
    logic [15:0] third_reg;
    logic [15:0] third_next;
    logic [32:0] product;
    logic        wr_en;
    logic [1:0]  index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= lmas_pkg::FIRST_DELAY_RESET;
            second_reg     <= lmas_pkg::SECOND_DELAY_RESET;
            transition_reg <= lmas_pkg::TRANSITION_RESET;
        end
        else if (wr_en)
        begin
            if (index == lmas_pkg::REG_FIRST_DELAY)
            begin
                first_reg <= pwdata[15:0];
            end
            if (index == lmas_pkg::REG_SECOND_DELAY)
            begin
                second_reg <= pwdata[15:0];
            end
            if (index == lmas_pkg::REG_TRANSITION)
            begin
                transition_reg <= pwdata[15:0];
            end
        end
    end

    // One third of the transition time, by reciprocal multiplication, registered.
    assign product    = {17'd0, transition_reg} * lmas_pkg::RECIP3;
    assign third_next = product[32:17];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            third_reg <= lmas_pkg::THIRD_RESET;
        end
        else
        begin
            third_reg <= third_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (index)
            lmas_pkg::REG_FIRST_DELAY:  prdata = {16'd0, first_reg};
            lmas_pkg::REG_SECOND_DELAY: prdata = {16'd0, second_reg};
            lmas_pkg::REG_TRANSITION:   prdata = {16'd0, transition_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.first_delay      = first_reg;
    assign cfg.second_delay     = second_reg;
    assign cfg.third_transition = third_reg;

endmodule

>>> rtl/lmas_core.sv
// Animation state and frame buffer; computes the next state for one request.
// Depends on lmas_pkg.
module lmas_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  lmas_pkg::item_t     item,
    input  lmas_pkg::cfg_t      cfg,
    output lmas_pkg::frame_t    frame,
    output lmas_pkg::frame_t    frame_next,
    output logic [3:0]          bright_next,
    output logic                changed
);

    lmas_pkg::frame_t frame_reg;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        animating_reg, animating_next;
    logic [7:0]  animation_reg, animation_next;
    logic [3:0]  normal_stage_reg, normal_stage_next;
    logic        normal_down_reg, normal_down_next;
    logic        march_phase_reg, march_phase_next;
    logic [3:0]  spin_step_reg, spin_step_next;
    logic [1:0]  ring_step_reg, ring_step_next;
    logic        ring_down_reg, ring_down_next;
    logic [2:0]  updown_step_reg, updown_step_next;
    logic        updown_down_reg, updown_down_next;
    logic [2:0]  leftright_step_reg, leftright_step_next;
    logic        leftright_down_reg, leftright_down_next;
    logic [3:0]  bright_reg;

    always_comb
    begin
        logic [15:0] el_inc;
        logic [15:0] hold;
        logic [3:0]  stage_sat;
        logic [4:0]  stage_up;
        logic [3:0]  stage_new;
        logic        due;
        lmas_pkg::bounce_t bn;

        frame_next          = frame_reg;
        elapsed_next        = elapsed_reg;
        animating_next      = animating_reg;
        animation_next      = animation_reg;
        normal_stage_next   = normal_stage_reg;
        normal_down_next    = normal_down_reg;
        march_phase_next    = march_phase_reg;
        spin_step_next      = spin_step_reg;
        ring_step_next      = ring_step_reg;
        ring_down_next      = ring_down_reg;
        updown_step_next    = updown_step_reg;
        updown_down_next    = updown_down_reg;
        leftright_step_next = leftright_step_reg;
        leftright_down_next = leftright_down_reg;
        bright_next         = bright_reg;

        el_inc = (elapsed_reg == lmas_pkg::ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
        stage_sat = (normal_stage_reg > lmas_pkg::NORMAL_LAST) ? lmas_pkg::NORMAL_LAST
                                                               : normal_stage_reg;
        stage_up  = {1'b0, normal_stage_reg} + 5'd1;
        stage_new = stage_sat;
        bn        = '0;

        // Hold time of the running animation.
        unique case (animation_reg)
            lmas_pkg::ANIM_NORMAL:
            begin
                if (stage_sat == 4'd0 || stage_sat == lmas_pkg::NORMAL_LAST)
                begin
                    hold = cfg.first_delay;
                end
                else if (stage_sat == lmas_pkg::NORMAL_MID)
                begin
                    hold = cfg.second_delay;
                end
                else
                begin
                    hold = cfg.third_transition;
                end
            end
            lmas_pkg::ANIM_SPIN: hold = lmas_pkg::SPIN_MS;
            default:             hold = lmas_pkg::SLOW_MS;
        endcase
        due = (el_inc >= hold) && (animation_reg <= lmas_pkg::ANIM_LEFTRIGHT);

        unique case (item.mode)
            lmas_pkg::MODE_TICK:
            begin
                elapsed_next = el_inc;
                if (animating_reg && due)
                begin
                    elapsed_next = 16'd0;
                    if (animation_reg != lmas_pkg::ANIM_NORMAL)
                    begin
                        frame_next = '0;
                    end
                    unique case (animation_reg)
                        lmas_pkg::ANIM_NORMAL:
                        begin
                            if (normal_down_reg)
                            begin
                                stage_new = (stage_sat == 4'd0) ? 4'd0 : stage_sat - 4'd1;
                                normal_down_next = (stage_new != 4'd0);
                            end
                            else if (stage_up >= {1'b0, lmas_pkg::NORMAL_LAST})
                            begin
                                stage_new = lmas_pkg::NORMAL_LAST;
                                normal_down_next = 1'b1;
                            end
                            else
                            begin
                                stage_new = stage_up[3:0];
                            end
                            normal_stage_next = stage_new;
                            frame_next[0] = lmas_pkg::stage_pat(stage_new);
                            frame_next[1] = ~lmas_pkg::stage_pat(stage_new);
                            frame_next[2] = lmas_pkg::stage_pat(stage_new);
                            frame_next[3] = ~lmas_pkg::stage_pat(stage_new);
                            frame_next[4] = lmas_pkg::stage_pat(stage_new);
                        end
                        lmas_pkg::ANIM_MARCH:
                        begin
                            frame_next[0] = march_phase_reg ? 8'h55 : 8'hAA;
                            frame_next[1] = march_phase_reg ? 8'hAA : 8'h55;
                            frame_next[2] = march_phase_reg ? 8'h55 : 8'hAA;
                            frame_next[3] = march_phase_reg ? 8'hAA : 8'h55;
                            frame_next[4] = march_phase_reg ? 8'h55 : 8'hAA;
                            march_phase_next = !march_phase_reg;
                        end
                        lmas_pkg::ANIM_SPIN:
                        begin
                            if (spin_step_reg < lmas_pkg::SPIN_STEPS)
                            begin
                                frame_next[lmas_pkg::spin_row(spin_step_reg)] =
                                    lmas_pkg::spin_bits(spin_step_reg);
                            end
                            spin_step_next = (spin_step_reg < lmas_pkg::SPIN_STEPS - 4'd1)
                                           ? spin_step_reg + 4'd1 : 4'd0;
                        end
                        lmas_pkg::ANIM_RING:
                        begin
                            for (int r = 0; r < 5; r++)
                            begin
                                frame_next[r] = lmas_pkg::ring_img(ring_step_reg, 3'(r));
                            end
                            bn = lmas_pkg::bounce({1'b0, ring_step_reg}, ring_down_reg,
                                                  lmas_pkg::RING_TOP);
                            ring_step_next = bn.step[1:0];
                            ring_down_next = bn.down;
                        end
                        lmas_pkg::ANIM_UPDOWN:
                        begin
                            if (updown_step_reg <= lmas_pkg::UPDOWN_TOP)
                            begin
                                frame_next[updown_step_reg] = 8'hFF;
                            end
                            bn = lmas_pkg::bounce(updown_step_reg, updown_down_reg,
                                                  lmas_pkg::UPDOWN_TOP);
                            updown_step_next = bn.step;
                            updown_down_next = bn.down;
                        end
                        default:
                        begin
                            if (leftright_step_reg <= lmas_pkg::LEFTRIGHT_TOP)
                            begin
                                for (int r = 0; r < 5; r++)
                                begin
                                    frame_next[r] = 8'h80 >> leftright_step_reg;
                                end
                            end
                            bn = lmas_pkg::bounce(leftright_step_reg, leftright_down_reg,
                                                  lmas_pkg::LEFTRIGHT_TOP);
                            leftright_step_next = bn.step;
                            leftright_down_next = bn.down;
                        end
                    endcase
                end
            end
            lmas_pkg::MODE_ALL_ON:
            begin
                animating_next = 1'b0;
                frame_next     = '1;
            end
            lmas_pkg::MODE_OFF:
            begin
                animating_next = 1'b0;
                frame_next     = '0;
            end
            lmas_pkg::MODE_BRIGHT:
            begin
                if (item.value <= 8'd15)
                begin
                    bright_next = item.value[3:0];
                end
            end
            lmas_pkg::MODE_ANIM:
            begin
                animating_next = 1'b1;
                animation_next = item.value;
            end
            default:
            begin
            end
        endcase
    end

    assign changed = (frame_next != frame_reg) || (bright_next != bright_reg);
    assign frame   = frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg          <= '0;
            elapsed_reg        <= 16'd0;
            animating_reg      <= 1'b1;
            animation_reg      <= lmas_pkg::ANIM_NORMAL;
            normal_stage_reg   <= 4'd0;
            normal_down_reg    <= 1'b0;
            march_phase_reg    <= 1'b1;
            spin_step_reg      <= 4'd0;
            ring_step_reg      <= 2'd0;
            ring_down_reg      <= 1'b0;
            updown_step_reg    <= 3'd0;
            updown_down_reg    <= 1'b0;
            leftright_step_reg <= 3'd0;
            leftright_down_reg <= 1'b0;
            bright_reg         <= lmas_pkg::BRIGHT_RESET;
        end
        else if (enable)
        begin
            frame_reg          <= frame_next;
            elapsed_reg        <= elapsed_next;
            animating_reg      <= animating_next;
            animation_reg      <= animation_next;
            normal_stage_reg   <= normal_stage_next;
            normal_down_reg    <= normal_down_next;
            march_phase_reg    <= march_phase_next;
            spin_step_reg      <= spin_step_next;
            ring_step_reg      <= ring_step_next;
            ring_down_reg      <= ring_down_next;
            updown_step_reg    <= updown_step_next;
            updown_down_reg    <= updown_down_next;
            leftright_step_reg <= leftright_step_next;
            leftright_down_reg <= leftright_down_next;
            bright_reg         <= bright_next;
        end
    end

endmodule

>>> rtl/led_matrix_animation_sequencer_unit.sv
// A request is taken into the input register and gives its result, if any, in the result register.
// Throughput: one request per cycle; the state update is one pass of logic between
// the input register and the result register, so only a stalled result slows intake.
// Reset (rst_n low, asynchronous): frame dark, brightness 15, normal animation armed,
// delays 1000/1000/300 ms, input and result registers empty.
// Depends on lmas_pkg, lmas_cfg_regs and lmas_core.
module led_matrix_animation_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  row0,
    output logic [7:0]  row1,
    output logic [7:0]  row2,
    output logic [7:0]  row3,
    output logic [7:0]  row4,
    output logic [7:0]  row5,
    output logic [3:0]  intensity,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              in_valid_reg, in_valid_next;
    lmas_pkg::item_t   item_reg;
    logic              out_valid_reg, out_valid_next;
    lmas_pkg::frame_t  out_frame_reg;
    logic [3:0]        out_bright_reg;
    logic              advance;
    logic              load;
    lmas_pkg::cfg_t    cfg;
    lmas_pkg::frame_t  frame;
    lmas_pkg::frame_t  frame_next;
    logic [3:0]        bright_next;
    logic              changed;

    lmas_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmas_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (advance),
        .item        (item_reg),
        .cfg         (cfg),
        .frame       (frame),
        .frame_next  (frame_next),
        .bright_next (bright_next),
        .changed     (changed)
    );

    // The held request is processed once the result slot is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    assign in_valid_next  = load || (in_valid_reg && !advance);
    assign out_valid_next = advance ? changed : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.mode  <= mode;
            item_reg.value <= value;
        end
        if (advance && changed)
        begin
            out_frame_reg  <= frame_next;
            out_bright_reg <= bright_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign row0      = out_frame_reg[0];
    assign row1      = out_frame_reg[1];
    assign row2      = out_frame_reg[2];
    assign row3      = out_frame_reg[3];
    assign row4      = out_frame_reg[4];
    assign row5      = out_frame_reg[5];
    assign intensity = out_bright_reg;

`ifndef SYNTHESIS
    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a processed request");

    a_held_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("held request lost or changed");

    a_all_on_lights_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.mode == lmas_pkg::MODE_ALL_ON) |=> (frame == '1))
        else $error("all-on request did not light the whole frame");

    a_result_matches_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && changed) |=> (out_frame_reg == frame))
        else $error("result frame differs from the frame buffer");
`endif

endmodule

>>> sim/led_matrix_animation_sequencer_unit_test.sv
// Self-checking testbench for led_matrix_animation_sequencer_unit: directed table and runs, plus
// random tick and command traffic, checked against a cycle-free model of the display state.
// Depends on lmas_pkg and the RTL under rtl/.
module led_matrix_animation_sequencer_unit_test;
    import lmas_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int SCRIPT_ROWS = 26;
    localparam int PICTURE_ROWS = 5;

    localparam logic [2:0] MODE_JUNK_LO = 3'd5;
    localparam logic [2:0] MODE_JUNK_HI = 3'd7;
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic [0:8][7:0] STAGE_PATTERN =
        {8'h55, 8'hD5, 8'h95, 8'hB5, 8'hAA, 8'h2A, 8'h6A, 8'h55, 8'h55};
    localparam logic [0:13][2:0] SPIN_ROW =
        {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0};
    localparam logic [0:13][7:0] SPIN_BITS =
        {8'h40, 8'h80, 8'h80, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h04, 8'h04, 8'h08,
         8'h10, 8'h20};
    localparam logic [0:2][0:4][7:0] RING_IMAGE =
        {8'h78, 8'h84, 8'h84, 8'h84, 8'h78,
         8'h00, 8'h78, 8'h48, 8'h78, 8'h00,
         8'h00, 8'h00, 8'h30, 8'h00, 8'h00};

    localparam frame_t DARK = '0;
    localparam frame_t LIT = {NumRows{8'hFF}};

    typedef struct packed {
        frame_t     rows;
        logic [3:0] level;
    } display_t;

    typedef enum logic [1:0] {PREDICTED, NO_RESULT, FIXED_RESULT} check_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  value;
        logic [15:0] count;
        check_t      how;
        display_t    shows;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [7:0]  value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  row0, row1, row2, row3, row4, row5;
    logic [3:0]  intensity;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    led_matrix_animation_sequencer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .row0(row0), .row1(row1), .row2(row2), .row3(row3), .row4(row4), .row5(row5),
        .intensity(intensity),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Model of the display engine.
    logic [15:0] first_delay, second_delay, transition_total;
    frame_t      shown;
    logic [3:0]  bright_level;
    logic [15:0] ms_count;
    logic        running;
    logic [7:0]  anim_sel;
    logic [3:0]  stage;
    logic        stage_down;
    logic        march_first;
    logic [3:0]  spin_pos;
    logic [2:0]  ring_pos, bar_row, bar_col;
    logic        ring_dn, bar_row_dn, bar_col_dn;

    display_t    frames_due[$];
    stim_row_t   script [SCRIPT_ROWS];

    int unsigned failures = 0;
    int unsigned requests_done = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_off_go = 1'b0;

    task automatic reset_model();
        first_delay = FIRST_DELAY_RESET;
        second_delay = SECOND_DELAY_RESET;
        transition_total = TRANSITION_RESET;
        shown = DARK;
        bright_level = BRIGHT_RESET;
        ms_count = '0;
        running = 1'b1;
        anim_sel = ANIM_NORMAL;
        stage = '0;
        stage_down = 1'b0;
        march_first = 1'b1;
        spin_pos = '0;
        ring_pos = '0;
        ring_dn = 1'b0;
        bar_row = '0;
        bar_row_dn = 1'b0;
        bar_col = '0;
        bar_col_dn = 1'b0;
    endtask

    // True when the hold time has run out; the millisecond count then restarts.
    function automatic logic hold_elapsed(input logic [15:0] hold);
        if (ms_count < hold)
            return 1'b0;
        ms_count = '0;
        return 1'b1;
    endfunction

    task automatic paint_rows(input logic [7:0] p);
        shown[0] = p;
        shown[1] = ~p;
        shown[2] = p;
        shown[3] = ~p;
        shown[4] = p;
    endtask

    task automatic step_bounce(inout logic [2:0] pos, inout logic dn, input logic [2:0] top);
        if (dn)
        begin
            if (pos == 3'd0)
            begin
                pos = 3'd1;
                dn = 1'b0;
            end
            else
                pos = pos - 3'd1;
        end
        else if (pos == top)
        begin
            pos = top - 3'd1;
            dn = 1'b1;
        end
        else
            pos = pos + 3'd1;
    endtask

    task automatic step_animation();
        logic [15:0] hold;
        case (anim_sel)
            ANIM_NORMAL:
            begin
                if (stage == 4'd0 || stage == NORMAL_LAST)
                    hold = first_delay;
                else if (stage == NORMAL_MID)
                    hold = second_delay;
                else
                    hold = transition_total / 16'd3;
                if (hold_elapsed(hold))
                begin
                    if (stage_down)
                    begin
                        if (stage != 4'd0)
                            stage = stage - 4'd1;
                        if (stage == 4'd0)
                            stage_down = 1'b0;
                    end
                    else
                    begin
                        stage = stage + 4'd1;
                        if (stage >= NORMAL_LAST)
                        begin
                            stage = NORMAL_LAST;
                            stage_down = 1'b1;
                        end
                    end
                    paint_rows(STAGE_PATTERN[stage]);
                end
            end
            ANIM_MARCH:
            begin
                if (hold_elapsed(SLOW_MS))
                begin
                    shown = DARK;
                    paint_rows(march_first ? STAGE_PATTERN[0] : STAGE_PATTERN[4]);
                    march_first = !march_first;
                end
            end
            ANIM_SPIN:
            begin
                if (hold_elapsed(SPIN_MS))
                begin
                    shown = DARK;
                    shown[SPIN_ROW[spin_pos]] = SPIN_BITS[spin_pos];
                    spin_pos = (spin_pos == SPIN_STEPS - 4'd1) ? 4'd0 : spin_pos + 4'd1;
                end
            end
            ANIM_RING:
            begin
                if (hold_elapsed(SLOW_MS))
                begin
                    shown = DARK;
                    for (int r = 0; r < PICTURE_ROWS; r++)
                        shown[r] = RING_IMAGE[ring_pos[1:0]][r];
                    step_bounce(ring_pos, ring_dn, RING_TOP);
                end
            end
            ANIM_UPDOWN:
            begin
                if (hold_elapsed(SLOW_MS))
                begin
                    shown = DARK;
                    shown[bar_row] = 8'hFF;
                    step_bounce(bar_row, bar_row_dn, UPDOWN_TOP);
                end
            end
            ANIM_LEFTRIGHT:
            begin
                if (hold_elapsed(SLOW_MS))
                begin
                    shown = DARK;
                    for (int r = 0; r < PICTURE_ROWS; r++)
                        shown[r] = 8'h80 >> bar_col;
                    step_bounce(bar_col, bar_col_dn, LEFTRIGHT_TOP);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Applies one request to the model; a result is due when frame or brightness changed.
    task automatic advance_display(input logic [2:0] m, input logic [7:0] v,
                                   output logic changed, output display_t after);
        display_t prior;
        prior = {shown, bright_level};
        case (m)
            MODE_TICK:
            begin
                if (ms_count != ELAPSED_MAX)
                    ms_count = ms_count + 16'd1;
                if (running)
                    step_animation();
            end
            MODE_ALL_ON:
            begin
                running = 1'b0;
                shown = LIT;
            end
            MODE_OFF:
            begin
                running = 1'b0;
                shown = DARK;
            end
            MODE_BRIGHT:
            begin
                if (v <= 8'd15)
                    bright_level = v[3:0];
            end
            MODE_ANIM:
            begin
                running = 1'b1;
                anim_sel = v;
            end
            default:
            begin
            end
        endcase
        after = {shown, bright_level};
        changed = (after != prior);
    endtask

    task automatic offer_request(input logic [2:0] m, input logic [7:0] v, input check_t how,
                                 input display_t typed);
        logic     changed;
        display_t next;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        advance_display(m, v, changed, next);
        if (how == FIXED_RESULT)
            frames_due.push_back(typed);
        else if (how == PREDICTED && changed)
            frames_due.push_back(next);
        if (m < MODE_JUNK_LO)
            requests_done++;
    endtask

    // Lets the block run empty; extra cycles cover requests still in flight with no result.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FIRST_DELAY:  first_delay = data[15:0];
            REG_SECOND_DELAY: second_delay = data[15:0];
            REG_TRANSITION:   transition_total = data[15:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic write_delays(input logic [31:0] first, input logic [31:0] second,
                                input logic [31:0] trans);
        write_register(REG_FIRST_DELAY, first);
        write_register(REG_SECOND_DELAY, second);
        write_register(REG_TRANSITION, trans);
    endtask

    // Random traffic: mostly runs of ticks, with commands of every kind between them.
    task automatic run_mix(input int unsigned item_goal);
        int unsigned start_items;
        int unsigned pick;
        int unsigned burst;
        logic [7:0]  v;
        start_items = requests_done;
        while (requests_done - start_items < item_goal)
        begin
            pick = $urandom_range(99);
            v = 8'($urandom);
            if (pick < 20)
                offer_request(MODE_ANIM, ($urandom_range(9) == 0) ? v : 8'($urandom_range(5)),
                              PREDICTED, '0);
            else if (pick < 30)
                offer_request(MODE_BRIGHT, ($urandom_range(3) == 0) ? v : 8'($urandom_range(15)),
                              PREDICTED, '0);
            else if (pick < 35)
                offer_request(MODE_ALL_ON, v, PREDICTED, '0);
            else if (pick < 39)
                offer_request(MODE_OFF, v, PREDICTED, '0);
            else if (pick < 42)
                offer_request(3'($urandom_range(MODE_JUNK_LO, MODE_JUNK_HI)), v, PREDICTED, '0);
            else
            begin
                burst = $urandom_range(1, 40);
                repeat (burst) offer_request(MODE_TICK, 8'($urandom), PREDICTED, '0);
            end
        end
    endtask

    task automatic check_display();
        display_t got;
        display_t want;
        got = display_t'({row5, row4, row3, row2, row1, row0, intensity});
        if (frames_due.size() == 0)
        begin
            failures++;
            $display("%0t: expected no result, got rows %h intensity %h",
                     $time, got.rows, got.level);
            return;
        end
        want = frames_due.pop_front();
        for (int r = 0; r < NumRows; r++)
        begin
            if (got.rows[r] !== want.rows[r])
            begin
                failures++;
                $display("%0t: row%0d expected %h, got %h", $time, r, want.rows[r], got.rows[r]);
            end
        end
        if (got.level !== want.level)
        begin
            failures++;
            $display("%0t: intensity expected %h, got %h", $time, want.level, got.level);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_display();
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off_go && hold_count < HOLD_OFF_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count++;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        script[0]  = '{MODE_BRIGHT, 8'd16, 16'd1, NO_RESULT, '0};
        script[1]  = '{MODE_BRIGHT, 8'd0, 16'd1, FIXED_RESULT, display_t'({DARK, 4'd0})};
        script[2]  = '{MODE_BRIGHT, 8'd15, 16'd1, FIXED_RESULT, display_t'({DARK, 4'd15})};
        script[3]  = '{MODE_ALL_ON, 8'h00, 16'd1, FIXED_RESULT, display_t'({LIT, 4'd15})};
        script[4]  = '{MODE_ALL_ON, 8'hFF, 16'd1, NO_RESULT, '0};
        script[5]  = '{MODE_OFF, 8'h00, 16'd1, FIXED_RESULT, display_t'({DARK, 4'd15})};
        script[6]  = '{MODE_JUNK_LO, 8'hAA, 16'd1, NO_RESULT, '0};
        script[7]  = '{MODE_JUNK_HI, 8'h55, 16'd1, NO_RESULT, '0};
        script[8]  = '{MODE_BRIGHT, 8'hFF, 16'd1, NO_RESULT, '0};
        // Stopped display: ticks only advance the millisecond count.
        script[9]  = '{MODE_TICK, 8'h00, 16'd20, NO_RESULT, '0};
        script[10] = '{MODE_ANIM, 8'hFF, 16'd1, NO_RESULT, '0};
        script[11] = '{MODE_TICK, 8'h00, 16'd240, NO_RESULT, '0};
        script[12] = '{MODE_ANIM, 8'd6, 16'd1, NO_RESULT, '0};
        script[13] = '{MODE_ANIM, ANIM_MARCH, 16'd1, NO_RESULT, '0};
        // The count is already past 250, so the first tick draws the first march pattern.
        script[14] = '{MODE_TICK, 8'h00, 16'd1, FIXED_RESULT,
                       display_t'({8'h00, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 4'd15})};
        script[15] = '{MODE_ANIM, ANIM_SPIN, 16'd1, NO_RESULT, '0};
        script[16] = '{MODE_TICK, 8'h00, 16'd110, PREDICTED, '0};
        script[17] = '{MODE_ANIM, ANIM_RING, 16'd1, NO_RESULT, '0};
        script[18] = '{MODE_TICK, 8'h00, 16'd150, PREDICTED, '0};
        script[19] = '{MODE_ANIM, ANIM_UPDOWN, 16'd1, NO_RESULT, '0};
        script[20] = '{MODE_TICK, 8'h00, 16'd150, PREDICTED, '0};
        script[21] = '{MODE_ANIM, ANIM_LEFTRIGHT, 16'd1, NO_RESULT, '0};
        script[22] = '{MODE_TICK, 8'h00, 16'd150, PREDICTED, '0};
        script[23] = '{MODE_ANIM, ANIM_NORMAL, 16'd1, NO_RESULT, '0};
        script[24] = '{MODE_TICK, 8'h00, 16'd20, PREDICTED, '0};
        script[25] = '{MODE_BRIGHT, 8'd9, 16'd1, PREDICTED, '0};

        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
            for (int k = 0; k < script[i].count; k++)
                offer_request(script[i].mode, script[i].value, script[i].how, script[i].shows);
        drain_results();

        // Longest holds: the normal animation stays where it is.
        write_delays(32'hFFFF, 32'hFFFF, 32'hFFFF);
        offer_request(MODE_OFF, 8'h00, PREDICTED, '0);
        offer_request(MODE_ANIM, ANIM_NORMAL, PREDICTED, '0);
        repeat (20) offer_request(MODE_TICK, 8'h00, PREDICTED, '0);
        drain_results();

        write_delays(32'd0, 32'd0, 32'd0);
        run_mix(120);
        drain_results();

        // Long receiver hold-off while brightness changes keep coming.
        hold_off_go = 1'b1;
        for (int i = 0; i < 60; i++)
            offer_request(MODE_BRIGHT, i[0] ? 8'd4 : 8'd11, PREDICTED, '0);
        drain_results();

        send_idle_pct = 74;
        write_delays(32'($urandom_range(0, 40)), 32'($urandom_range(0, 40)),
                     32'($urandom_range(0, 120)));
        write_register(REG_SPARE, $urandom);
        run_mix(120);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 74;
        write_delays({16'($urandom), 16'($urandom_range(0, 30))},
                     {16'($urandom), 16'($urandom_range(0, 30))},
                     {16'($urandom), 16'($urandom_range(0, 90))});
        run_mix(120);
        drain_results();

        send_idle_pct = 9;
        recv_stall_pct = 9;
        write_delays(32'(FIRST_DELAY_RESET), 32'(SECOND_DELAY_RESET), 32'(TRANSITION_RESET));
        run_mix(120);
        drain_results();
        repeat (8) @(posedge clk);

        if (failures == 0 && frames_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
